FILE: sv/mlmm_pkg.sv
`timescale 1ns / 1ps
package mlmm_pkg;

  localparam int unsigned WordW   = 128;
  localparam int unsigned HalfW   = 64;
  localparam int unsigned LaneCnt = 16;
  localparam int unsigned ValW    = 16;
  localparam int unsigned IdxW    = 4;
  localparam int unsigned InW     = 256;
  localparam int unsigned OutW    = 168;

  localparam logic [15:0] TopNarrow = 16'h00FF;
  localparam logic [15:0] TopWide   = 16'hFFFF;

  typedef enum logic [2:0] {
    CFG_MINMAX_MODE  = 3'd0,
    CFG_MASK_CONST   = 3'd1,
    CFG_SRC_PACKET   = 3'd2,
    CFG_POST_ADJUST  = 3'd3,
    CFG_STEP_PACKET  = 3'd4,
    CFG_CONST_WORD   = 3'd5,
    CFG_MAX_TIE_HIGH = 3'd6,
    CFG_MIN_TIE_HIGH = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ADJ_NONE = 2'd0,
    ADJ_INC  = 2'd1,
    ADJ_DEC  = 2'd2,
    ADJ_RSVD = 2'd3
  } adj_op_t;

  typedef struct packed {
    logic [1:0]  minmax_mode;
    logic        mask_from_const;
    logic        source_from_packet;
    logic [1:0]  post_adjust;
    logic        step_from_packet;
    logic [31:0] const_word;
    logic        max_tie_high;
    logic        min_tie_high;
  } cfg_t;

  typedef struct packed {
    logic            valid;
    logic [ValW-1:0] value;
    logic [IdxW-1:0] index;
  } sel_t;

  // Combines two candidates; a holds the lower lane index.
  function automatic sel_t pick(sel_t a, sel_t b, logic is_max, logic tie_high);
    logic better;
    if (is_max) begin
      better = tie_high ? (b.value >= a.value) : (b.value > a.value);
    end else begin
      better = tie_high ? (b.value <= a.value) : (b.value < a.value);
    end
    if (b.valid && (!a.valid || better)) begin
      return b;
    end
    return a;
  endfunction

endpackage

FILE: sv/masked_lane_minmax_post_adjust_unit.sv
`timescale 1ns / 1ps
// Words pass through one input register, then the result register.
// One word per cycle unless out_tready stalls; lane search is a four-level compare tree.
// in_tready drops only while both registers hold words and out_tready is low.
// Reset is synchronous and active low; it clears both valid flags and all settings to zero.
module masked_lane_minmax_post_adjust_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // mem_lo, mem_hi, pkt_lo, pkt_hi
  input  logic [mlmm_pkg::InW-1:0]      in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // new_mem_lo, new_mem_hi, raw_value, adjusted_value, chosen_lane, mask_zero, 3 zero bits
  output logic [mlmm_pkg::OutW-1:0]     out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [31:0]                   cfg_data
);
  import mlmm_pkg::*;

  cfg_t              cfg_r;
  logic              s1_v_r;
  logic [WordW-1:0]  s1_mem_r;
  logic [WordW-1:0]  s1_pkt_r;
  logic              out_v_r;
  logic [OutW-1:0]   out_data_r;
  logic [OutW-1:0]   out_data_nxt;
  logic              s2_ready;
  logic              wide;
  logic [31:0]       mask32;
  logic [15:0]       mask;
  logic [WordW-1:0]  src;
  logic [WordW-1:0]  new_mem;
  logic [ValW-1:0]   adj_value;
  sel_t              sel;

  assign cfg_ready  = 1'b1;
  assign s2_ready   = !out_v_r || out_tready;
  assign in_tready  = !s1_v_r || s2_ready;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MINMAX_MODE:  cfg_r.minmax_mode        <= cfg_data[1:0];
        CFG_MASK_CONST:   cfg_r.mask_from_const    <= cfg_data[0];
        CFG_SRC_PACKET:   cfg_r.source_from_packet <= cfg_data[0];
        CFG_POST_ADJUST:  cfg_r.post_adjust        <= cfg_data[1:0];
        CFG_STEP_PACKET:  cfg_r.step_from_packet   <= cfg_data[0];
        CFG_CONST_WORD:   cfg_r.const_word         <= cfg_data;
        CFG_MAX_TIE_HIGH: cfg_r.max_tie_high       <= cfg_data[0];
        CFG_MIN_TIE_HIGH: cfg_r.min_tie_high       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_mem_r <= in_tdata[WordW-1:0];
      s1_pkt_r <= in_tdata[InW-1:WordW];
    end
  end

  always_comb begin
    wide   = cfg_r.minmax_mode[1];
    mask32 = cfg_r.mask_from_const ? cfg_r.const_word : s1_pkt_r[31:0];
    mask   = wide ? {8'h00, mask32[7:0]} : mask32[15:0];
    src    = cfg_r.source_from_packet ? s1_pkt_r : s1_mem_r;
  end

  mlmm_search u_search (
    .src      (src),
    .mask     (mask),
    .wide     (wide),
    .is_max   (cfg_r.minmax_mode[0]),
    .tie_high (cfg_r.minmax_mode[0] ? cfg_r.max_tie_high : cfg_r.min_tie_high),
    .sel      (sel)
  );

  mlmm_adjust u_adjust (
    .cfg       (cfg_r),
    .sel       (sel),
    .pkt_low   (s1_pkt_r[23:0]),
    .mem       (s1_mem_r),
    .new_mem   (new_mem),
    .adj_value (adj_value)
  );

  assign out_data_nxt = {3'b000, (mask == 16'h0000), sel.index, adj_value, sel.value, new_mem};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s2_ready) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_v_r) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

FILE: sv/mlmm_search.sv
`timescale 1ns / 1ps
module mlmm_search (
  input  logic [mlmm_pkg::WordW-1:0]   src,
  input  logic [mlmm_pkg::LaneCnt-1:0] mask,
  input  logic                         wide,
  input  logic                         is_max,
  input  logic                         tie_high,
  output mlmm_pkg::sel_t               sel
);
  import mlmm_pkg::*;

  sel_t l0 [16];
  sel_t l1 [8];
  sel_t l2 [4];
  sel_t l3 [2];
  sel_t top;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      l0[i].valid = mask[i];
      l0[i].index = IdxW'(i);
      if (wide) begin
        l0[i].value = (i < 8) ? src[16*(i%8) +: 16] : '0;
      end else begin
        l0[i].value = {8'h00, src[8*i +: 8]};
      end
    end
    for (int i = 0; i < 8; i++) begin
      l1[i] = pick(l0[2*i], l0[2*i+1], is_max, tie_high);
    end
    for (int i = 0; i < 4; i++) begin
      l2[i] = pick(l1[2*i], l1[2*i+1], is_max, tie_high);
    end
    for (int i = 0; i < 2; i++) begin
      l3[i] = pick(l2[2*i], l2[2*i+1], is_max, tie_high);
    end
    top = pick(l3[0], l3[1], is_max, tie_high);
    sel.valid = top.valid;
    sel.value = top.valid ? top.value : '0;
    sel.index = top.valid ? top.index : '0;
  end

endmodule

FILE: sv/mlmm_adjust.sv
`timescale 1ns / 1ps
module mlmm_adjust (
  input  mlmm_pkg::cfg_t              cfg,
  input  mlmm_pkg::sel_t              sel,
  input  logic [23:0]                 pkt_low,
  input  logic [mlmm_pkg::WordW-1:0]  mem,
  output logic [mlmm_pkg::WordW-1:0]  new_mem,
  output logic [mlmm_pkg::ValW-1:0]   adj_value
);
  import mlmm_pkg::*;

  logic        wide;
  logic [7:0]  step;
  logic [16:0] sum;
  logic [15:0] top;
  logic        do_adj;
  adj_op_t     op;

  always_comb begin
    wide = cfg.minmax_mode[1];
    op   = adj_op_t'(cfg.post_adjust);
    top  = wide ? TopWide : TopNarrow;
    if (cfg.step_from_packet) begin
      step = cfg.mask_from_const ? (wide ? pkt_low[7:0] : pkt_low[7:0]) :
             (wide ? pkt_low[15:8] : pkt_low[23:16]);
      if (cfg.mask_from_const) begin
        step = pkt_low[7:0];
      end
    end else begin
      step = !cfg.mask_from_const ? cfg.const_word[7:0] :
             (wide ? cfg.const_word[15:8] : cfg.const_word[23:16]);
    end
    sum       = {1'b0, sel.value} + {9'h000, step};
    adj_value = sel.value;
    do_adj    = 1'b0;
    case (op)
      ADJ_INC: begin
        do_adj    = sel.valid;
        adj_value = (sum > {1'b0, top}) ? top : sum[15:0];
      end
      ADJ_DEC: begin
        do_adj    = sel.valid;
        adj_value = (sel.value > {8'h00, step}) ? (sel.value - {8'h00, step}) : '0;
      end
      default: begin
        do_adj = 1'b0;
      end
    endcase
    if (!do_adj) begin
      adj_value = sel.value;
    end
    new_mem = mem;
    if (do_adj && !cfg.source_from_packet) begin
      if (wide) begin
        new_mem[{sel.index[2:0], 4'b0000} +: 16] = adj_value;
      end else begin
        new_mem[{sel.index, 3'b000} +: 8] = adj_value[7:0];
      end
    end
  end

endmodule

FILE: sv/mlmm_checker.sv
`timescale 1ns / 1ps
module mlmm_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [mlmm_pkg::OutW-1:0] out_tdata
);
  import mlmm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[164] |-> out_tdata[163:128] == 36'h0)
    else $error("empty mask gave a nonzero selection");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 out_tready |=> out_tvalid)
    else $error("accepted word did not reach the output");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind masked_lane_minmax_post_adjust_unit mlmm_checker u_mlmm_checker (.*);

FILE: tb/masked_lane_minmax_post_adjust_unit_tb.sv
`timescale 1ns / 1ps
module masked_lane_minmax_post_adjust_unit_tb;
  import mlmm_pkg::*;

  localparam logic [1:0] MODE_MIN8  = 2'd0;
  localparam logic [1:0] MODE_MAX8  = 2'd1;
  localparam logic [1:0] MODE_MIN16 = 2'd2;
  localparam logic [1:0] MODE_MAX16 = 2'd3;

  localparam int CycleLimit   = 200000;
  localparam int RandomPhases = 12;
  localparam int PhaseItems   = 50;
  localparam logic [63:0] Ones = {64{1'b1}};

  // Field order matches out_tdata, lowest bits last in the list.
  typedef struct packed {
    logic [2:0]  pad;
    logic        mask_zero;
    logic [3:0]  sel_idx;
    logic [15:0] adj_val;
    logic [15:0] raw_val;
    logic [63:0] mem_hi;
    logic [63:0] mem_lo;
  } lane_result_t;

  typedef struct {
    cfg_t         c;
    logic [255:0] data;
    bit           has_exp;
    lane_result_t exp;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  // mem_lo, mem_hi, pkt_lo, pkt_hi
  logic [InW-1:0]      in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  // new_mem_lo, new_mem_hi, raw_value, adjusted_value, chosen_lane, mask_zero, 3 zero bits
  logic [OutW-1:0]     out_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [2:0]          cfg_index = '0;
  logic [31:0]         cfg_data = '0;

  lane_result_t pending_words[$];
  stim_row_t    plan[$];
  cfg_t         cur_cfg;
  int           mismatches = 0;
  int           cycle_cnt = 0;
  bit           no_gaps = 1'b0;

  masked_lane_minmax_post_adjust_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic cfg_t mk_cfg(logic [1:0] mode, logic mconst, logic spkt,
                                  adj_op_t op, logic steppkt, logic [31:0] cw,
                                  logic maxth, logic minth);
    cfg_t c;
    c.minmax_mode        = mode;
    c.mask_from_const    = mconst;
    c.source_from_packet = spkt;
    c.post_adjust        = op;
    c.step_from_packet   = steppkt;
    c.const_word         = cw;
    c.max_tie_high       = maxth;
    c.min_tie_high       = minth;
    return c;
  endfunction

  function automatic lane_result_t mk_result(logic [63:0] lo, logic [63:0] hi,
                                             logic [15:0] raw, logic [15:0] adj,
                                             logic [3:0] idx, logic mz);
    lane_result_t r;
    r = '0;
    r.mem_lo    = lo;
    r.mem_hi    = hi;
    r.raw_val   = raw;
    r.adj_val   = adj;
    r.sel_idx   = idx;
    r.mask_zero = mz;
    return r;
  endfunction

  // Masked min/max search over the chosen word, then the saturating adjust and write-back.
  function automatic lane_result_t predict_lane_pick(cfg_t c, logic [255:0] w);
    logic [63:0]  pkt_lo;
    logic [127:0] src;
    logic [127:0] memw;
    logic         wide;
    logic         is_max;
    logic         found;
    logic         take;
    logic [15:0]  mask;
    logic [15:0]  v;
    logic [15:0]  best;
    logic [15:0]  adj_v;
    logic [15:0]  top;
    logic [3:0]   best_i;
    logic [7:0]   step;
    logic [16:0]  sum;
    int           lanes;
    lane_result_t r;
    pkt_lo = w[191:128];
    wide   = c.minmax_mode[1];
    is_max = c.minmax_mode[0];
    mask   = c.mask_from_const ? c.const_word[15:0] : pkt_lo[15:0];
    if (wide) begin
      mask[15:8] = 8'h00;
    end
    src    = c.source_from_packet ? w[255:128] : w[127:0];
    memw   = w[127:0];
    lanes  = wide ? 8 : 16;
    found  = 1'b0;
    best   = '0;
    best_i = '0;
    for (int i = 0; i < 16; i++) begin
      if (i < lanes && mask[i]) begin
        v = wide ? src[i*16 +: 16] : {8'h00, src[i*8 +: 8]};
        if (!found) begin
          take = 1'b1;
        end else if (is_max) begin
          take = c.max_tie_high ? (v >= best) : (v > best);
        end else begin
          take = c.min_tie_high ? (v <= best) : (v < best);
        end
        if (take) begin
          best   = v;
          best_i = 4'(i);
          found  = 1'b1;
        end
      end
    end
    adj_v = best;
    if ((c.post_adjust == ADJ_INC || c.post_adjust == ADJ_DEC) && mask != 16'h0000) begin
      top = wide ? TopWide : TopNarrow;
      if (c.step_from_packet) begin
        step = c.mask_from_const ? pkt_lo[7:0] : (wide ? pkt_lo[15:8] : pkt_lo[23:16]);
      end else begin
        step = !c.mask_from_const ? c.const_word[7:0] :
               (wide ? c.const_word[15:8] : c.const_word[23:16]);
      end
      if (c.post_adjust == ADJ_INC) begin
        sum   = {1'b0, best} + {9'h000, step};
        adj_v = (sum > {1'b0, top}) ? top : sum[15:0];
      end else begin
        adj_v = (best > {8'h00, step}) ? best - {8'h00, step} : 16'h0000;
      end
      if (!c.source_from_packet) begin
        if (wide) begin
          memw[best_i*16 +: 16] = adj_v;
        end else begin
          memw[best_i*8 +: 8] = adj_v[7:0];
        end
      end
    end
    r = mk_result(memw[63:0], memw[127:64], best, adj_v, best_i, mask == 16'h0000);
    return r;
  endfunction

  // Lanes that are often equal or near the ends of the range.
  function automatic logic [63:0] rand_half();
    logic [63:0] h;
    logic [7:0]  b;
    int          kind;
    kind = $urandom_range(0, 3);
    h = {$urandom, $urandom};
    if (kind >= 2) begin
      for (int i = 0; i < 8; i++) begin
        case ($urandom_range(0, 3))
          0: b = 8'h00;
          1: b = 8'h01;
          2: b = 8'hFE;
          default: b = 8'hFF;
        endcase
        if (kind == 3 && i > 0) begin
          b = h[7:0];
        end
        h[i*8 +: 8] = b;
      end
    end
    return h;
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    c = mk_cfg(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               adj_op_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom,
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    case ($urandom_range(0, 5))
      0: c.const_word = 32'h0000_0000;
      1: c.const_word = 32'hFFFF_FFFF;
      2: c.const_word[15:0] = 16'h0001 << $urandom_range(0, 15);
      default: ;
    endcase
    if (c.post_adjust == ADJ_RSVD && $urandom_range(0, 1) == 1) begin
      c.post_adjust = ADJ_INC;
    end
    return c;
  endfunction

  function automatic logic [255:0] rand_word();
    logic [63:0] pkt_lo;
    pkt_lo = rand_half();
    case ($urandom_range(0, 7))
      0: pkt_lo[31:0] = 32'h0000_0000;
      1: pkt_lo[15:0] = 16'h0001 << $urandom_range(0, 15);
      2: pkt_lo[15:0] = 16'hFFFF;
      3: pkt_lo[15:0] = 16'hFF00;
      default: ;
    endcase
    return {rand_half(), pkt_lo, rand_half(), rand_half()};
  endfunction

  task automatic add_row(cfg_t c, logic [255:0] data, bit has_exp, lane_result_t exp);
    stim_row_t row;
    row.c       = c;
    row.data    = data;
    row.has_exp = has_exp;
    row.exp     = exp;
    plan.push_back(row);
  endtask

  task automatic send_word(logic [255:0] data, lane_result_t exp);
    while (!no_gaps && $urandom_range(99) < 25) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    pending_words.push_back(exp);
  endtask

  // Drains the pipeline, then writes every register in one run of words.
  task automatic load_settings(cfg_t c);
    cfg_idx_t k;
    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    for (int i = 0; i < 8; i++) begin
      k = cfg_idx_t'(i);
      cfg_valid <= 1'b1;
      cfg_index <= k;
      case (k)
        CFG_MINMAX_MODE:  cfg_data <= {30'b0, c.minmax_mode};
        CFG_MASK_CONST:   cfg_data <= {31'b0, c.mask_from_const};
        CFG_SRC_PACKET:   cfg_data <= {31'b0, c.source_from_packet};
        CFG_POST_ADJUST:  cfg_data <= {30'b0, c.post_adjust};
        CFG_STEP_PACKET:  cfg_data <= {31'b0, c.step_from_packet};
        CFG_CONST_WORD:   cfg_data <= c.const_word;
        CFG_MAX_TIE_HIGH: cfg_data <= {31'b0, c.max_tie_high};
        default:          cfg_data <= {31'b0, c.min_tie_high};
      endcase
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cur_cfg = c;
  endtask

  always @(posedge clk) begin
    lane_result_t got;
    lane_result_t exp;
    got = lane_result_t'(out_tdata);
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_words.size() == 0) begin
        if (mismatches < 10) begin
          $display("Unexpected result word: %h", out_tdata);
        end
        mismatches++;
      end else begin
        exp = pending_words.pop_front();
        if (got.mem_lo !== exp.mem_lo || got.mem_hi !== exp.mem_hi ||
            got.raw_val !== exp.raw_val || got.adj_val !== exp.adj_val ||
            got.sel_idx !== exp.sel_idx || got.mask_zero !== exp.mask_zero ||
            got.pad !== exp.pad) begin
          if (mismatches < 10) begin
            $display("Mismatch: expected mem %h_%h raw %h adj %h idx %0d mz %b pad %b",
                     exp.mem_hi, exp.mem_lo, exp.raw_val, exp.adj_val, exp.sel_idx,
                     exp.mask_zero, exp.pad);
            $display("          actual   mem %h_%h raw %h adj %h idx %0d mz %b pad %b",
                     got.mem_hi, got.mem_lo, got.raw_val, got.adj_val, got.sel_idx,
                     got.mask_zero, got.pad);
          end
          mismatches++;
        end
      end
    end
    out_tready <= no_gaps || ($urandom_range(99) >= 25);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    lane_result_t none;
    cfg_t         c;
    none    = '0;
    cur_cfg = '0;

    add_row('0, '0, 1'b1, mk_result('0, '0, 16'h0000, 16'h0000, 4'd0, 1'b1));
    add_row('0, {64'h0, 64'h0, Ones, Ones}, 1'b1,
            mk_result(Ones, Ones, 16'h0000, 16'h0000, 4'd0, 1'b1));
    add_row(mk_cfg(MODE_MIN8, 0, 0, ADJ_NONE, 0, 32'h0, 0, 0),
            {64'h0, 64'hFFFF, Ones, Ones}, 1'b1,
            mk_result(Ones, Ones, 16'h00FF, 16'h00FF, 4'd0, 1'b0));
    add_row(mk_cfg(MODE_MAX8, 0, 0, ADJ_NONE, 0, 32'h0, 0, 0),
            {64'h0, 64'hFFFF, Ones, Ones}, 1'b1,
            mk_result(Ones, Ones, 16'h00FF, 16'h00FF, 4'd0, 1'b0));
    add_row(mk_cfg(MODE_MAX8, 0, 0, ADJ_NONE, 0, 32'h0, 1, 0),
            {64'h0, 64'hFFFF, Ones, Ones}, 1'b1,
            mk_result(Ones, Ones, 16'h00FF, 16'h00FF, 4'd15, 1'b0));
    add_row(mk_cfg(MODE_MIN16, 0, 0, ADJ_NONE, 0, 32'h0, 0, 1),
            {64'h0, 64'hFF, 64'h0, 64'h0}, 1'b1,
            mk_result('0, '0, 16'h0000, 16'h0000, 4'd7, 1'b0));
    add_row(mk_cfg(MODE_MAX8, 0, 0, ADJ_INC, 0, 32'hFF, 0, 0),
            {64'h0, 64'hFFFF, Ones, Ones}, 1'b1,
            mk_result(Ones, Ones, 16'h00FF, 16'h00FF, 4'd0, 1'b0));
    add_row(mk_cfg(MODE_MIN16, 0, 0, ADJ_DEC, 0, 32'hFF, 0, 0),
            {64'h0, 64'hFF, 64'h0, 64'h0}, 1'b1,
            mk_result('0, '0, 16'h0000, 16'h0000, 4'd0, 1'b0));
    add_row(mk_cfg(MODE_MAX16, 0, 0, ADJ_INC, 0, 32'h1, 0, 0),
            {64'h0, 64'hFF, Ones, Ones}, 1'b1,
            mk_result(Ones, Ones, 16'hFFFF, 16'hFFFF, 4'd0, 1'b0));
    add_row(mk_cfg(MODE_MIN8, 0, 0, ADJ_DEC, 1, 32'h0, 0, 0),
            {64'h5A5A, 64'h0030_F0F0, 64'h8899AABBCCDDEEFF, 64'h0011223344556677}, 1'b0, none);
    add_row(mk_cfg(MODE_MAX16, 0, 0, ADJ_INC, 0, 32'h0000_0005, 0, 0),
            {64'h0, 64'hAA, 64'hFFFD_1000_FFFE_2000, 64'h0001_FFFC_3000_4000}, 1'b0, none);
    add_row(mk_cfg(MODE_MAX8, 0, 0, ADJ_RSVD, 0, 32'h0000_0010, 0, 0),
            {64'h0, 64'hFFFF, 64'h0102030405060708, 64'h90A0B0C0D0E0F011}, 1'b0, none);
    add_row(mk_cfg(MODE_MIN16, 0, 1, ADJ_DEC, 1, 32'h0, 0, 0),
            {64'h1111_2222_3333_4444, 64'h0005_0006_0407_02F3, Ones, Ones}, 1'b0, none);
    add_row(mk_cfg(MODE_MAX8, 1, 0, ADJ_INC, 0, 32'h0040_8001, 0, 0),
            {64'h0, 64'h0, 64'hD0FFEEDDCCBBAA99, 64'h8877665544332280}, 1'b0, none);
    add_row(mk_cfg(MODE_MIN16, 1, 0, ADJ_DEC, 1, 32'h0000_3C81, 0, 0),
            {64'h0, 64'h0000_0000_0000_0042, 64'h0030_1000_2000_3000, 64'h4000_5000_6000_0010},
            1'b0, none);
    add_row(mk_cfg(MODE_MIN16, 0, 0, ADJ_INC, 0, 32'h7, 0, 0),
            {64'h0, 64'hFF00, 64'h1234, 64'h5678}, 1'b0, none);
    add_row(mk_cfg(MODE_MAX8, 0, 0, ADJ_INC, 0, 32'h10, 0, 0),
            {64'h0, 64'h8000, 64'hF800_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b0, none);
    add_row(mk_cfg(MODE_MIN16, 0, 0, ADJ_DEC, 0, 32'h07, 0, 0),
            {64'h0, 64'h0080, 64'h0005_0000_0000_0000, 64'h0}, 1'b0, none);
    add_row(mk_cfg(MODE_MAX16, 0, 0, ADJ_DEC, 1, 32'h0, 1, 0),
            {64'h0, 64'h0000_0000_0000_20FF, 64'h1234_5678_1234_0001, 64'h1234_0002_1234_0003},
            1'b0, none);
    add_row(mk_cfg(MODE_MIN8, 0, 1, ADJ_INC, 0, 32'hFF, 0, 0),
            {64'h0101_0101_0101_0101, 64'h0101_0101_0101_FFFE, Ones, 64'h0}, 1'b0, none);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].c != cur_cfg) begin
        load_settings(plan[i].c);
      end
      send_word(plan[i].data,
                plan[i].has_exp ? plan[i].exp : predict_lane_pick(cur_cfg, plan[i].data));
    end

    for (int p = 0; p < RandomPhases; p++) begin
      if (p == 0) begin
        c = mk_cfg(MODE_MAX16, 1, 1, ADJ_DEC, 1, 32'hFFFF_FFFF, 1, 1);
      end else if (p == 1) begin
        c = mk_cfg(MODE_MIN8, 0, 0, ADJ_NONE, 0, 32'h0, 0, 0);
      end else begin
        c = rand_cfg();
      end
      load_settings(c);
      no_gaps = (p == 5 || p == 6);
      for (int n = 0; n < PhaseItems; n++) begin
        logic [255:0] w;
        w = rand_word();
        send_word(w, predict_lane_pick(cur_cfg, w));
      end
      no_gaps = 1'b0;
    end

    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/mlmm_pkg.sv
sv/mlmm_search.sv
sv/mlmm_adjust.sv
sv/masked_lane_minmax_post_adjust_unit.sv
sv/mlmm_checker.sv
tb/masked_lane_minmax_post_adjust_unit_tb.sv
